// ===== rtl/core/bmat_pkg.sv =====
`default_nettype none

package bmat_pkg;

  localparam int MAX_DIM    = 256;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int DW_W       = DIM_W + 1;
  localparam int SUM_W      = 2 * DIM_W + 1;
  localparam int SUM_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int RUN_W      = 8;
  localparam int RECT_W     = 16;
  localparam int COORD_W    = RECT_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOUDIFY    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT   = 2'd3;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET   = 9'd256;
  localparam logic [RUN_W-1:0]      LIMIT_RESET = 8'd24;

  typedef struct packed {
    logic capture;
    logic cfg_we;
    logic ld_addr;
    logic ld_wr;
    logic q_calc;
    logic q_rd0;
    logic q_rd1;
    logic q_done;
  } bmat_cmd_t;

  function automatic logic [DW_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] w;
    w = {{(32 - CFG_DATA_W){1'b0}}, v};
    if (w == 32'd0) begin
      w = 32'd1;
    end else if (w > 32'(MAX_DIM)) begin
      w = 32'(MAX_DIM);
    end
    return w[DW_W-1:0];
  endfunction

  function automatic logic corner_zero(input logic [DW_W-1:0] x, input logic [DW_W-1:0] y);
    return (x == '0) || (y == '0);
  endfunction

  function automatic logic [2*DIM_W-1:0] corner_addr(input logic [DW_W-1:0] x,
                                                     input logic [DW_W-1:0] y);
    logic [DW_W-1:0] xm;
    logic [DW_W-1:0] ym;
    xm = x - DW_W'(1);
    ym = y - DW_W'(1);
    return {ym[DIM_W-1:0], xm[DIM_W-1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/binary_mask_area_test_unit.sv =====
// Pixel load: count/table read (LD_ADDR), then write (LD_WR), back to back.
// Area query: states Q_CALC, Q_RD0, Q_RD1 and Q_DONE from accept to result;
// the four table corners are read two at a time through its two read ports.
// Result register frees the input while a result waits on out_stall.
// Reset (rst_n low, synchronous): 256x256 mask, cloudify off, run limit 24,
// load position at origin; table contents are not cleared.
`default_nettype none

module binary_mask_area_test_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_opcode,
  input  wire logic                                   in_solid,
  input  wire logic signed [bmat_pkg::RECT_W-1:0]     in_rect_left,
  input  wire logic signed [bmat_pkg::RECT_W-1:0]     in_rect_top,
  input  wire logic signed [bmat_pkg::RECT_W-1:0]     in_rect_right,
  input  wire logic signed [bmat_pkg::RECT_W-1:0]     in_rect_bottom,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_hit,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic        [bmat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [bmat_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bmat_pkg::*;

  bmat_cmd_t cmd;

  bmat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  bmat_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_solid       (in_solid),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_right  (in_rect_right),
    .in_rect_bottom (in_rect_bottom),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_hit        (out_hit)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bmat_ram.sv =====
`default_nettype none

module bmat_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr_a,
  input  wire logic [ADDR_W-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]  rd_data_a,
  output logic      [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bmat_ctrl.sv =====
`default_nettype none

module bmat_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_opcode,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  output bmat_pkg::bmat_cmd_t       cmd
);

  import bmat_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LD_ADDR = 3'd1;
  localparam logic [2:0] ST_LD_WR   = 3'd2;
  localparam logic [2:0] ST_Q_CALC  = 3'd3;
  localparam logic [2:0] ST_Q_RD0   = 3'd4;
  localparam logic [2:0] ST_Q_RD1   = 3'd5;
  localparam logic [2:0] ST_Q_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       take;
  logic       accept;
  logic [2:0] start_state;

  assign slot_free   = !out_valid_r || !out_stall;
  assign take        = (state_r == ST_IDLE) || (state_r == ST_LD_WR) ||
                       ((state_r == ST_Q_DONE) && slot_free);
  assign in_stall    = !take;
  assign accept      = in_valid && take;
  assign start_state = (in_opcode == OP_QUERY) ? ST_Q_CALC : ST_LD_ADDR;
  assign cfg_ready   = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.cfg_we  = cfg_valid && (state_r == ST_IDLE);
    cmd.ld_addr = (state_r == ST_LD_ADDR);
    cmd.ld_wr   = (state_r == ST_LD_WR);
    cmd.q_calc  = (state_r == ST_Q_CALC);
    cmd.q_rd0   = (state_r == ST_Q_RD0);
    cmd.q_rd1   = (state_r == ST_Q_RD1);
    cmd.q_done  = (state_r == ST_Q_DONE) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = start_state;
        end
      end
      ST_LD_ADDR: state_nxt = ST_LD_WR;
      ST_LD_WR: begin
        state_nxt = accept ? start_state : ST_IDLE;
      end
      ST_Q_CALC: state_nxt = ST_Q_RD0;
      ST_Q_RD0:  state_nxt = ST_Q_RD1;
      ST_Q_RD1:  state_nxt = ST_Q_DONE;
      ST_Q_DONE: begin
        if (slot_free) begin
          state_nxt = accept ? start_state : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.q_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bmat_dp.sv =====
`default_nettype none

module bmat_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire bmat_pkg::bmat_cmd_t                   cmd,
  input  wire logic                                  in_solid,
  input  wire logic signed [bmat_pkg::RECT_W-1:0]    in_rect_left,
  input  wire logic signed [bmat_pkg::RECT_W-1:0]    in_rect_top,
  input  wire logic signed [bmat_pkg::RECT_W-1:0]    in_rect_right,
  input  wire logic signed [bmat_pkg::RECT_W-1:0]    in_rect_bottom,
  input  wire logic        [bmat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [bmat_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                       out_hit
);

  import bmat_pkg::*;

  localparam logic [DIM_W-1:0] DIM_ONE   = DIM_W'(1);
  localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1);

  // captured item
  logic                     solid_r;
  logic signed [RECT_W-1:0] l_r, t_r, r_r, b_r;

  // configuration
  logic [DW_W-1:0]  width_r, width_nxt;
  logic [DW_W-1:0]  height_r, height_nxt;
  logic             cloud_r, cloud_nxt;
  logic [RUN_W-1:0] limit_r, limit_nxt;

  // load state
  logic [DIM_W-1:0]   col_r, col_nxt;
  logic [DIM_W-1:0]   row_r, row_nxt;
  logic [DW_W-1:0]    rsum_r, rsum_nxt;
  logic [MAX_DIM-1:0] cnt_vld_r, cnt_vld_nxt;

  // query state
  logic [DW_W-1:0]          xl_r, xr_r, yt_r, yb_r;
  logic                     empty_r;
  logic signed [SUM_W:0]    lower_r;
  logic                     hit_r;

  // memories
  logic                   sum_we, sum_rd_en;
  logic [2*DIM_W-1:0]     sum_wr_addr, sum_rd_addr_a, sum_rd_addr_b;
  logic [SUM_W-1:0]       sum_wr_data, sum_rd_a, sum_rd_b;
  logic [RUN_W-1:0]       cnt_wr_data, cnt_rd;

  // load datapath
  logic                   wrap;
  logic [DIM_W-1:0]       col_eff, row_eff, row_above;
  logic [RUN_W-1:0]       cnt_cur;
  logic                   px;
  logic [DW_W-1:0]        rsum_new;
  logic [SUM_W-1:0]       above;
  logic [DW_W-1:0]        col_inc, row_inc;
  logic                   cfg_restart;

  // query datapath
  logic signed [COORD_W-1:0] ls, ts, rs, bs, rmax, bmax;
  logic signed [COORD_W-1:0] lc, tc, rc, bc, xr_full, yb_full;
  logic                      empty_nxt;
  logic [SUM_W-1:0]          ca, cb, da, db;
  logic signed [SUM_W:0]     upper, lower;

  assign wrap      = ({1'b0, col_r} >= width_r) || ({1'b0, row_r} >= height_r);
  assign col_eff   = wrap ? '0 : col_r;
  assign row_eff   = wrap ? '0 : row_r;
  assign row_above = row_eff - DIM_ONE;

  always_comb begin
    cnt_cur     = cnt_vld_r[col_r] ? cnt_rd : '0;
    px          = solid_r;
    cnt_wr_data = '0;
    if (solid_r) begin
      if (cnt_cur < limit_r) begin
        cnt_wr_data = cnt_cur + RUN_W'(1);
      end else begin
        cnt_wr_data = cnt_cur;
        if (cloud_r) begin
          px = 1'b0;
        end
      end
    end
    rsum_new    = ((col_r == '0) ? '0 : rsum_r) + {{(DW_W-1){1'b0}}, px};
    above       = (row_r == '0) ? '0 : sum_rd_a;
    sum_wr_data = {{(SUM_W-DW_W){1'b0}}, rsum_new} + above;
    col_inc     = {1'b0, col_r} + DW_W'(1);
    row_inc     = {1'b0, row_r} + DW_W'(1);
  end

  assign sum_we      = cmd.ld_wr;
  assign sum_wr_addr = {row_r, col_r};
  assign sum_rd_en   = cmd.ld_addr || cmd.q_rd0 || cmd.q_rd1;

  always_comb begin
    sum_rd_addr_a = {row_above, col_eff};
    sum_rd_addr_b = corner_addr(xl_r, yb_r);
    if (cmd.q_rd0) begin
      sum_rd_addr_a = corner_addr(xr_r, yb_r);
      sum_rd_addr_b = corner_addr(xl_r, yb_r);
    end else if (cmd.q_rd1) begin
      sum_rd_addr_a = corner_addr(xr_r, yt_r);
      sum_rd_addr_b = corner_addr(xl_r, yt_r);
    end
  end

  bmat_ram #(
    .WIDTH (SUM_W),
    .DEPTH (SUM_DEPTH)
  ) u_sum_ram (
    .clk       (clk),
    .we        (sum_we),
    .wr_addr   (sum_wr_addr),
    .wr_data   (sum_wr_data),
    .rd_en     (sum_rd_en),
    .rd_addr_a (sum_rd_addr_a),
    .rd_addr_b (sum_rd_addr_b),
    .rd_data_a (sum_rd_a),
    .rd_data_b (sum_rd_b)
  );

  bmat_ram #(
    .WIDTH (RUN_W),
    .DEPTH (MAX_DIM)
  ) u_cnt_ram (
    .clk       (clk),
    .we        (cmd.ld_wr),
    .wr_addr   (col_r),
    .wr_data   (cnt_wr_data),
    .rd_en     (cmd.ld_addr),
    .rd_addr_a (col_eff),
    .rd_addr_b (col_eff),
    .rd_data_a (cnt_rd),
    .rd_data_b ()
  );

  // configuration and load position
  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    cloud_nxt   = cloud_r;
    limit_nxt   = limit_r;
    cfg_restart = 1'b0;
    if (cmd.cfg_we) begin
      cfg_restart = 1'b1;
      case (cfg_index)
        CFG_MASK_WIDTH:  width_nxt  = clamp_dim(cfg_data);
        CFG_MASK_HEIGHT: height_nxt = clamp_dim(cfg_data);
        CFG_CLOUDIFY:    cloud_nxt  = cfg_data[0];
        CFG_RUN_LIMIT:   limit_nxt  = cfg_data[RUN_W-1:0];
        default:         cfg_restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    rsum_nxt    = rsum_r;
    cnt_vld_nxt = cnt_vld_r;
    if (cfg_restart) begin
      col_nxt     = '0;
      row_nxt     = '0;
      rsum_nxt    = '0;
      cnt_vld_nxt = '0;
    end else if (cmd.ld_addr) begin
      col_nxt = col_eff;
      row_nxt = row_eff;
      if (wrap) begin
        rsum_nxt    = '0;
        cnt_vld_nxt = '0;
      end
    end else if (cmd.ld_wr) begin
      rsum_nxt           = rsum_new;
      cnt_vld_nxt[col_r] = 1'b1;
      if (col_inc >= width_r) begin
        col_nxt = '0;
        if (row_inc >= height_r) begin
          row_nxt     = '0;
          rsum_nxt    = '0;
          cnt_vld_nxt = '0;
        end else begin
          row_nxt = row_inc[DIM_W-1:0];
        end
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end
  end

  // query rectangle clamp
  always_comb begin
    ls      = COORD_W'(l_r);
    ts      = COORD_W'(t_r);
    rs      = COORD_W'(r_r);
    bs      = COORD_W'(b_r);
    rmax    = $signed({{(COORD_W-DW_W){1'b0}}, width_r}) - COORD_ONE;
    bmax    = $signed({{(COORD_W-DW_W){1'b0}}, height_r}) - COORD_ONE;
    empty_nxt = (ls > rs) || (ts > bs) || (rs < 0) || (ls > rmax) ||
                (bs < 0) || (ts > bmax);
    lc      = (ls < 0) ? '0 : ls;
    tc      = (ts < 0) ? '0 : ts;
    rc      = (rs > rmax) ? rmax : rs;
    bc      = (bs > bmax) ? bmax : bs;
    xr_full = rc + COORD_ONE;
    yb_full = bc + COORD_ONE;
  end

  assign da    = corner_zero(xr_r, yb_r) ? '0 : sum_rd_a;
  assign db    = corner_zero(xl_r, yb_r) ? '0 : sum_rd_b;
  assign lower = $signed({1'b0, da}) - $signed({1'b0, db});
  assign ca    = corner_zero(xr_r, yt_r) ? '0 : sum_rd_a;
  assign cb    = corner_zero(xl_r, yt_r) ? '0 : sum_rd_b;
  assign upper = $signed({1'b0, ca}) - $signed({1'b0, cb});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      solid_r <= in_solid;
      l_r     <= in_rect_left;
      t_r     <= in_rect_top;
      r_r     <= in_rect_right;
      b_r     <= in_rect_bottom;
    end
    if (cmd.q_calc) begin
      xl_r    <= lc[DW_W-1:0];
      yt_r    <= tc[DW_W-1:0];
      xr_r    <= xr_full[DW_W-1:0];
      yb_r    <= yb_full[DW_W-1:0];
      empty_r <= empty_nxt;
    end
    if (cmd.q_rd1) begin
      lower_r <= lower;
    end
    if (cmd.q_done) begin
      hit_r <= !empty_r && (lower_r > upper);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= clamp_dim(DIM_RESET);
      height_r  <= clamp_dim(DIM_RESET);
      cloud_r   <= 1'b0;
      limit_r   <= LIMIT_RESET;
      col_r     <= '0;
      row_r     <= '0;
      rsum_r    <= '0;
      cnt_vld_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      cloud_r   <= cloud_nxt;
      limit_r   <= limit_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      rsum_r    <= rsum_nxt;
      cnt_vld_r <= cnt_vld_nxt;
    end
  end

  assign out_hit = hit_r;

endmodule

`default_nettype wire
